### hdl/glh_pkg.sv
// Shared constants, types and helper functions for the grey level histogram.
package glh_pkg;

    localparam int COUNT_BITS     = 24;
    localparam int NUM_BINS       = 256;
    localparam int BIN_BITS       = $clog2(NUM_BINS);
    localparam int FRAC_BITS      = 16;
    localparam int STEP_BITS      = $clog2(FRAC_BITS);
    localparam int OUT_COUNT_BITS = 24;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);

    localparam logic [QUEUE_AW:0]      QUEUE_FULL = (QUEUE_AW + 1)'(QUEUE_DEPTH);
    localparam logic [STEP_BITS-1:0]   STEP_LAST  = STEP_BITS'(FRAC_BITS - 1);
    localparam logic [FRAC_BITS:0]     FRAC_ONE   = (FRAC_BITS + 1)'(1) << FRAC_BITS;
    localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = '1;

    localparam logic [1:0] CMD_COUNT = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        OP_PIXEL,
        OP_READ,
        OP_CLEAR
    } op_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    typedef struct packed {
        logic [1:0]          command;
        logic [BIN_BITS-1:0] pixel_value;
        logic [BIN_BITS-1:0] bin_select;
    } item_t;

    typedef struct packed {
        logic [BIN_BITS-1:0]       bin_echo;
        logic [OUT_COUNT_BITS-1:0] bin_count;
        logic [FRAC_BITS:0]        bin_fraction;
        logic                      no_pixels;
    } result_t;

    typedef struct packed {
        op_t                 op;
        logic [BIN_BITS-1:0] addr;
    } queue_item_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic [COUNT_BITS-1:0] total;
        logic [BIN_BITS-1:0]   bin;
    } div_req_t;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [OUT_COUNT_BITS-1:0] count_to_out(
        input logic [COUNT_BITS-1:0] c
    );
        logic [COUNT_BITS+OUT_COUNT_BITS-1:0] wide;
        wide = {{OUT_COUNT_BITS{1'b0}}, c};
        return wide[OUT_COUNT_BITS-1:0];
    endfunction

endpackage

### hdl/grey_level_histogram.sv
// Top level of the grey level histogram: front end, back end, divider and result register.
//
// The item channel carries one command per beat: count a pixel, read one bin,
// or clear all bins and the total. A beat with an unused command code is taken
// and dropped. The result channel carries one beat per read command: the bin,
// its saturated count, its share of all pixels in U1.16 and an empty flag.
// Pixel beats are taken at one per cycle; the front end queues up to four
// commands, so item_stall rises only when the queue is full.
// A read's result beat waits mainly on the divider, which produces one fraction bit
// per cycle; the back end holds further commands while a read waits for the divider.
// Reset empties the queue and the result register and marks every bin and the
// total as zero at once; the first beat may follow directly.
// While result_stall is high the result register holds its beat, the divider
// holds the next result, and commands keep filling the queue until it is full.
module grey_level_histogram (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  glh_pkg::item_t   item,
    output logic             item_stall,
    output logic             result_valid,
    input  logic             result_stall,
    output glh_pkg::result_t result
);

    logic                 q_valid;
    glh_pkg::queue_item_t q_item;
    logic                 q_pop;
    logic                 div_idle;
    logic                 div_start;
    glh_pkg::div_req_t    div_req;
    logic                 div_done;
    logic                 div_take;
    glh_pkg::result_t     div_result;
    logic                 out_valid_reg, out_valid_next;
    glh_pkg::result_t     result_reg;

    glh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_stall (item_stall),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    glh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .div_idle  (div_idle),
        .div_start (div_start),
        .div_req   (div_req)
    );

    glh_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .req    (div_req),
        .idle   (div_idle),
        .done   (div_done),
        .take   (div_take),
        .result (div_result)
    );

    assign div_take = div_done && (!out_valid_reg || !result_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (div_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_take)
        begin
            result_reg <= div_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

endmodule

### hdl/glh_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module glh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

### hdl/glh_front.sv
// Front end: accepts input beats, classifies the command and queues the operation.
module glh_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  glh_pkg::item_t       item,
    output logic                 item_stall,
    output logic                 q_valid,
    output glh_pkg::queue_item_t q_item,
    input  logic                 q_pop
);

    glh_pkg::queue_item_t              fifo_reg [glh_pkg::QUEUE_DEPTH];
    glh_pkg::queue_item_t              cls;
    logic                              push_ok;
    logic                              push;
    logic [glh_pkg::QUEUE_AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [glh_pkg::QUEUE_AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [glh_pkg::QUEUE_AW:0]        cnt_reg, cnt_next;

    always_comb
    begin
        push_ok = 1'b0;
        cls.op = glh_pkg::OP_PIXEL;
        cls.addr = item.pixel_value;
        case (item.command)
            glh_pkg::CMD_COUNT:
            begin
                push_ok = 1'b1;
            end
            glh_pkg::CMD_READ:
            begin
                push_ok = 1'b1;
                cls.op = glh_pkg::OP_READ;
                cls.addr = item.bin_select;
            end
            glh_pkg::CMD_CLEAR:
            begin
                push_ok = 1'b1;
                cls.op = glh_pkg::OP_CLEAR;
            end
            default:
            begin
                push_ok = 1'b0;
            end
        endcase
    end

    assign item_stall = (cnt_reg == glh_pkg::QUEUE_FULL);
    assign push       = item_valid && !item_stall && push_ok;
    assign q_valid    = (cnt_reg != '0);
    assign q_item     = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next = cnt_reg;
        if (push && !q_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (q_pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= cls;
        end
    end

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= glh_pkg::QUEUE_FULL)
        else $error("Queue fill count exceeds its depth.");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("Back end popped an empty queue.");

endmodule

### hdl/glh_back.sv
// Back end: bin memory read-modify-write, pixel total, clearing and read dispatch.
module glh_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  glh_pkg::queue_item_t q_item,
    output logic                 q_pop,
    input  logic                 div_idle,
    output logic                 div_start,
    output glh_pkg::div_req_t    div_req
);

    logic                              s1_valid_reg, s1_valid_next;
    glh_pkg::op_t                      s1_op_reg;
    logic [glh_pkg::BIN_BITS-1:0]      s1_addr_reg;
    logic [glh_pkg::NUM_BINS-1:0]      vbit_reg, vbit_next;
    logic [glh_pkg::COUNT_BITS-1:0]    total_reg, total_next;
    logic                              fwd_valid_reg, fwd_valid_next;
    logic [glh_pkg::BIN_BITS-1:0]      fwd_addr_reg;
    logic [glh_pkg::COUNT_BITS-1:0]    fwd_data_reg;
    logic [glh_pkg::COUNT_BITS-1:0]    ram_rdata;
    logic [glh_pkg::COUNT_BITS-1:0]    old_count;
    logic [glh_pkg::COUNT_BITS-1:0]    new_count;
    logic                              s1_done;
    logic                              advance;
    logic                              ram_we;
    logic                              do_clear;

    glh_ram #(
        .WIDTH (glh_pkg::COUNT_BITS),
        .DEPTH (glh_pkg::NUM_BINS)
    ) u_bins (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_addr_reg),
        .wdata (new_count),
        .re    (q_pop),
        .raddr (q_item.addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        case (s1_op_reg)
            glh_pkg::OP_READ:
            begin
                s1_done = div_idle;
            end
            default:
            begin
                s1_done = 1'b1;
            end
        endcase
    end

    assign advance   = !s1_valid_reg || s1_done;
    assign q_pop     = q_valid && advance;
    assign ram_we    = s1_valid_reg && (s1_op_reg == glh_pkg::OP_PIXEL);
    assign do_clear  = s1_valid_reg && (s1_op_reg == glh_pkg::OP_CLEAR);
    assign div_start = s1_valid_reg && (s1_op_reg == glh_pkg::OP_READ) && div_idle;

    // The write of the previous cycle is not yet visible in the registered read data.
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
        begin
            old_count = fwd_data_reg;
        end
        else if (vbit_reg[s1_addr_reg])
        begin
            old_count = ram_rdata;
        end
        else
        begin
            old_count = '0;
        end
        new_count = glh_pkg::sat_inc(old_count);
    end

    always_comb
    begin
        s1_valid_next = advance ? q_valid : s1_valid_reg;
        vbit_next = vbit_reg;
        total_next = total_reg;
        fwd_valid_next = fwd_valid_reg;
        if (ram_we)
        begin
            vbit_next[s1_addr_reg] = 1'b1;
            total_next = glh_pkg::sat_inc(total_reg);
            fwd_valid_next = 1'b1;
        end
        if (do_clear)
        begin
            vbit_next = '0;
            total_next = '0;
            fwd_valid_next = 1'b0;
        end
    end

    assign div_req.count = old_count;
    assign div_req.total = total_reg;
    assign div_req.bin   = s1_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            vbit_reg <= '0;
            total_reg <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            vbit_reg <= vbit_next;
            total_reg <= total_next;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_op_reg <= q_item.op;
            s1_addr_reg <= q_item.addr;
        end
        if (ram_we)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= new_count;
        end
    end

    a_read_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (s1_op_reg == glh_pkg::OP_READ) && !div_idle)
        |=> (s1_valid_reg && $stable(s1_addr_reg)))
        else $error("A waiting read left the stage before the divider took it.");

    a_fwd_total: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid_reg |-> (total_reg != '0))
        else $error("A bin was written but the pixel total is zero.");

endmodule

### hdl/glh_div.sv
// Bit-serial divider that turns a bin count and the total into a 16-bit fraction.
module glh_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  glh_pkg::div_req_t req,
    output logic              idle,
    output logic              done,
    input  logic              take,
    output glh_pkg::result_t  result
);

    glh_pkg::div_state_t               state_reg, state_next;
    logic [glh_pkg::STEP_BITS-1:0]     step_reg, step_next;
    logic [glh_pkg::COUNT_BITS-1:0]    rem_reg;
    logic [glh_pkg::COUNT_BITS-1:0]    den_reg;
    logic [glh_pkg::COUNT_BITS-1:0]    cnt_reg;
    logic [glh_pkg::FRAC_BITS-1:0]     quo_reg;
    logic                              int_reg;
    logic                              empty_reg;
    logic [glh_pkg::BIN_BITS-1:0]      bin_reg;
    logic [glh_pkg::COUNT_BITS:0]      shifted;
    logic [glh_pkg::COUNT_BITS:0]      diff;
    logic                              ge;
    logic                              int_bit;
    logic                              is_run;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            glh_pkg::DIV_IDLE:
            begin
                if (start)
                begin
                    state_next = (req.total == '0) ? glh_pkg::DIV_DONE : glh_pkg::DIV_RUN;
                end
            end
            glh_pkg::DIV_RUN:
            begin
                if (step_reg == glh_pkg::STEP_LAST)
                begin
                    state_next = glh_pkg::DIV_DONE;
                end
            end
            glh_pkg::DIV_DONE:
            begin
                if (take)
                begin
                    state_next = glh_pkg::DIV_IDLE;
                end
            end
            default:
            begin
                state_next = glh_pkg::DIV_IDLE;
            end
        endcase
    end

    always_comb
    begin
        idle = 1'b0;
        done = 1'b0;
        is_run = 1'b0;
        case (state_reg)
            glh_pkg::DIV_IDLE:
            begin
                idle = 1'b1;
            end
            glh_pkg::DIV_RUN:
            begin
                is_run = 1'b1;
            end
            glh_pkg::DIV_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                idle = 1'b0;
            end
        endcase
    end

    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = !diff[glh_pkg::COUNT_BITS];
    assign int_bit = (req.count >= req.total);
    assign step_next = is_run ? step_reg + 1'b1 : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= glh_pkg::DIV_IDLE;
            step_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (idle && start)
        begin
            den_reg <= req.total;
            cnt_reg <= req.count;
            bin_reg <= req.bin;
            quo_reg <= '0;
            empty_reg <= (req.total == '0);
            int_reg <= (req.total != '0) && int_bit;
            rem_reg <= int_bit ? req.count - req.total : req.count;
        end
        else if (is_run)
        begin
            quo_reg <= {quo_reg[glh_pkg::FRAC_BITS-2:0], ge};
            rem_reg <= ge ? diff[glh_pkg::COUNT_BITS-1:0] : shifted[glh_pkg::COUNT_BITS-1:0];
        end
    end

    assign result.bin_echo     = bin_reg;
    assign result.bin_count    = glh_pkg::count_to_out(cnt_reg);
    assign result.bin_fraction = int_reg ? glh_pkg::FRAC_ONE : {1'b0, quo_reg};
    assign result.no_pixels    = empty_reg;

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == glh_pkg::DIV_RUN) |-> (den_reg != '0))
        else $error("Divider runs with a zero pixel total.");

    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == glh_pkg::DIV_RUN) && !int_reg) |-> (rem_reg < den_reg))
        else $error("Divider remainder is not below the pixel total.");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the grey level histogram: directed and random command streams.
module tb;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 530;
    localparam int         ROUNDS       = 5;
    localparam int         DRAIN_CYCLES = 40;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    glh_pkg::item_t   item         = '0;
    logic             item_stall;
    logic             result_valid;
    logic             result_stall = 1'b0;
    glh_pkg::result_t result;

    logic [glh_pkg::COUNT_BITS-1:0] hist_bins [glh_pkg::NUM_BINS];
    logic [glh_pkg::COUNT_BITS-1:0] hist_total;
    glh_pkg::result_t               pending_reads [$];

    int errors        = 0;
    int beats_sent    = 0;
    int reads_checked = 0;
    int clears_sent   = 0;
    int stall_left    = 0;
    bit steady_flow   = 1'b0;

    grey_level_histogram i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item         (item),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #2 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic void clear_histogram();
        foreach (hist_bins[i])
            hist_bins[i] = '0;
        hist_total = '0;
    endfunction

    function automatic glh_pkg::result_t predict_read(logic [glh_pkg::BIN_BITS-1:0] sel);
        glh_pkg::result_t                                   r;
        logic [glh_pkg::COUNT_BITS+glh_pkg::FRAC_BITS-1:0]  share;
        share          = '0;
        r.bin_echo     = sel;
        r.bin_count    = hist_bins[sel];
        r.no_pixels    = (hist_total == '0);
        if (hist_total != '0)
        begin
            share = {hist_bins[sel], {glh_pkg::FRAC_BITS{1'b0}}} / hist_total;
            if (share > glh_pkg::FRAC_ONE)
                share = glh_pkg::FRAC_ONE;
        end
        r.bin_fraction = share[glh_pkg::FRAC_BITS:0];
        return r;
    endfunction

    function automatic void apply_item(glh_pkg::item_t it);
        case (it.command)
            glh_pkg::CMD_COUNT:
            begin
                if (hist_bins[it.pixel_value] != glh_pkg::COUNT_MAX)
                    hist_bins[it.pixel_value] = hist_bins[it.pixel_value] + 1'b1;
                if (hist_total != glh_pkg::COUNT_MAX)
                    hist_total = hist_total + 1'b1;
            end
            glh_pkg::CMD_READ:
                pending_reads.push_back(predict_read(it.bin_select));
            glh_pkg::CMD_CLEAR:
            begin
                clear_histogram();
                clears_sent++;
            end
            default:
                ;
        endcase
    endfunction

    task automatic send_item(logic [1:0] cmd, logic [glh_pkg::BIN_BITS-1:0] pix,
                             logic [glh_pkg::BIN_BITS-1:0] sel);
        glh_pkg::item_t it;
        int             gap;
        it = '{command: cmd, pixel_value: pix, bin_select: sel};
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        apply_item(it);
        beats_sent++;
        gap = steady_flow ? 0 : pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left = stall_left - 1;
        else
        begin
            result_stall <= !steady_flow && ($urandom_range(0, 2) == 0);
            stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        glh_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_reads.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat, expected none, actual %p",
                         $time, result);
            end
            else
            begin
                want = pending_reads.pop_front();
                check_field("bin_echo", 32'(want.bin_echo), 32'(result.bin_echo));
                check_field("bin_count", 32'(want.bin_count), 32'(result.bin_count));
                check_field("bin_fraction", 32'(want.bin_fraction),
                            32'(result.bin_fraction));
                check_field("no_pixels", 32'(want.no_pixels), 32'(result.no_pixels));
                reads_checked++;
            end
        end
    end

    task automatic test_empty_histogram();
        send_item(glh_pkg::CMD_READ, 8'h00, 8'h00);
        send_item(glh_pkg::CMD_READ, 8'hFF, 8'hFF);
        send_item(CMD_UNUSED, 8'hFF, 8'hFF);
        send_item(glh_pkg::CMD_READ, 8'h00, 8'h80);
    endtask

    task automatic test_extreme_levels();
        send_item(glh_pkg::CMD_COUNT, 8'h00, 8'hFF);
        send_item(glh_pkg::CMD_COUNT, 8'hFF, 8'h00);
        send_item(glh_pkg::CMD_COUNT, 8'hFF, 8'hFF);
        send_item(glh_pkg::CMD_READ, 8'hFF, 8'h00);
        send_item(glh_pkg::CMD_READ, 8'h00, 8'hFF);
        send_item(glh_pkg::CMD_READ, 8'hFF, 8'h80);
        send_item(CMD_UNUSED, 8'h00, 8'h00);
        send_item(glh_pkg::CMD_READ, 8'h55, 8'hFF);
    endtask

    task automatic test_full_share();
        send_item(glh_pkg::CMD_CLEAR, 8'hAA, 8'h55);
        send_item(glh_pkg::CMD_COUNT, 8'h07, 8'hFF);
        send_item(glh_pkg::CMD_COUNT, 8'h07, 8'h00);
        send_item(glh_pkg::CMD_READ, 8'hFF, 8'h07);
        send_item(glh_pkg::CMD_CLEAR, 8'hFF, 8'hFF);
        send_item(glh_pkg::CMD_READ, 8'h07, 8'h07);
    endtask

    task automatic test_random_stream();
        logic [glh_pkg::BIN_BITS-1:0] hot [4];
        logic [glh_pkg::BIN_BITS-1:0] pix;
        logic [glh_pkg::BIN_BITS-1:0] sel;
        int                           roll;
        for (int round = 0; round < ROUNDS; round++)
        begin
            steady_flow = (round == 2);
            foreach (hot[i])
                hot[i] = glh_pkg::BIN_BITS'($urandom_range(0, 255));
            for (int n = 0; n < RANDOM_ITEMS / ROUNDS; n++)
            begin
                roll = $urandom_range(0, 99);
                pix  = ($urandom_range(0, 3) == 0)
                       ? glh_pkg::BIN_BITS'($urandom_range(0, 255))
                       : hot[2'($urandom_range(0, 3))];
                sel  = ($urandom_range(0, 1) == 0)
                       ? glh_pkg::BIN_BITS'($urandom_range(0, 255))
                       : hot[2'($urandom_range(0, 3))];
                if (roll < 72)
                    send_item(glh_pkg::CMD_COUNT, pix, sel);
                else if (roll < 92)
                    send_item(glh_pkg::CMD_READ, pix, sel);
                else if (roll < 96)
                    send_item(glh_pkg::CMD_CLEAR, pix, sel);
                else
                    send_item(CMD_UNUSED, pix, sel);
            end
        end
        steady_flow = 1'b0;
    endtask

    initial
    begin
        clear_histogram();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_histogram();
        test_extreme_levels();
        test_full_share();
        test_random_stream();

        item_valid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d command beats, %0d of them clears, and checked %0d read results.",
                 beats_sent, clears_sent, reads_checked);
        $display("Empty, single-level, full-share and random skewed histograms were covered.");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
